// ----- hdl/anti_diagonal_reorder_top_defines.svh -----
// Assertion macros shared by the anti-diagonal reorder checker.
`ifndef ANTI_DIAGONAL_REORDER_TOP_DEFINES_SVH
`define ANTI_DIAGONAL_REORDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ADR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ADR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/adr_pkg.sv -----
// Shared types, constants and helpers for the anti-diagonal reorder block.
package adr_pkg;

  localparam int ROWS    = 8;
  localparam int COLS    = 8;
  localparam int DATA_W  = 32;
  localparam int CELLS   = ROWS * COLS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS);
  localparam int IDX_W   = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int KEY_W   = $clog2(ROWS + COLS - 1);
  localparam int VAL_W   = 32;  // width of the value fields at the ports
  localparam int RIDX_W  = 3;   // width of the row field at the port
  localparam int CIDX_W  = 3;   // width of the column field at the port

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } adr_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store the incoming word
    logic scan_init;  // rewind the scan to key 0
    logic scan_step;  // look at one grid position and advance
  } adr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // current scan position holds a valid cell
    logic empty;      // no valid cells left
    logic one_left;   // exactly one valid cell left
  } adr_stat_t;

  function automatic logic [IDX_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    cell_addr = IDX_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

// ----- hdl/adr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module adr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/adr_ctrl.sv -----
// Controller FSM: load phase and drain scan sequencing.
module adr_ctrl
  import adr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      final_element_i,
  input  adr_stat_t stat_i,
  output adr_cmd_t  cmd_o,
  output logic      busy_o
);

  adr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (final_element_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        busy_o = 1'b1;
        if (stat_i.empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
          // last valid cell found: drain is complete
          if (stat_i.hit && stat_i.one_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/adr_dpath.sv -----
// Datapath: cell store, valid marks, occupancy count and diagonal scan.
module adr_dpath
  import adr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  adr_cmd_t           cmd_i,
  input  logic [VAL_W-1:0]   element_value_i,
  input  logic [RIDX_W-1:0]  row_index_i,
  input  logic [CIDX_W-1:0]  column_index_i,
  output adr_stat_t          stat_o,
  output logic               result_valid_o,
  output logic [VAL_W-1:0]   out_value_o,
  output logic               last_of_run_o
);

  logic [CELLS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             emit_q, last_q;

  logic             in_grid;
  logic [IDX_W-1:0] waddr;
  logic             we;
  logic [KEY_W-1:0] col_cur;
  logic [KEY_W-1:0] key_nxt;
  logic [IDX_W-1:0] scan_addr;
  logic             hit;
  logic             re;
  logic [DATA_W-1:0] rdata;

  // load side
  assign in_grid = (int'(row_index_i) < ROWS) && (int'(column_index_i) < COLS);
  assign waddr   = cell_addr(ROW_W'(row_index_i), COL_W'(column_index_i));
  assign we      = cmd_i.load && in_grid;

  // scan side: column follows from key minus row
  assign col_cur   = KEY_W'(key_q - KEY_W'(row_q));
  assign key_nxt   = KEY_W'(key_q + 1'b1);
  assign scan_addr = cell_addr(row_q, COL_W'(col_cur));
  assign hit       = valid_q[scan_addr];
  assign re        = cmd_i.scan_step && hit;

  assign stat_o.hit      = hit;
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.one_left = (cnt_q == CNT_W'(1));

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    row_d   = row_q;
    if (we) begin
      valid_d[waddr] = 1'b1;
      if (!valid_q[waddr]) begin
        cnt_d = CNT_W'(cnt_q + 1'b1);
      end
    end
    if (cmd_i.scan_init) begin
      key_d = '0;
      row_d = '0;
    end
    if (cmd_i.scan_step) begin
      if (hit) begin
        valid_d[scan_addr] = 1'b0;
        cnt_d              = CNT_W'(cnt_q - 1'b1);
      end
      // walk down the anti-diagonal, else move to the next key
      if ((row_q != '0) && (int'(col_cur) < COLS - 1)) begin
        row_d = ROW_W'(row_q - 1'b1);
      end else begin
        key_d = key_nxt;
        row_d = (int'(key_nxt) < ROWS - 1) ? ROW_W'(key_nxt) : ROW_W'(ROWS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      key_q   <= '0;
      row_q   <= '0;
      emit_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      row_q   <= row_d;
      emit_q  <= re;
      last_q  <= re && stat_o.one_left;
    end
  end

  adr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (DATA_W'(element_value_i)),
    .re_i    (re),
    .raddr_i (scan_addr),
    .rdata_o (rdata)
  );

  assign result_valid_o = emit_q;
  assign out_value_o    = VAL_W'(rdata);
  assign last_of_run_o  = last_q;

endmodule

// ----- hdl/anti_diagonal_reorder_top.sv -----
// Top level of the anti-diagonal reorder block.
//
// Collects the elements of a jagged matrix (up to 8 x 8) and replays them in
// anti-diagonal order: key row+column ascending, row descending within a key.
// Loading: one word per cycle while busy_o is low; start_i with busy_o low
// accepts the word. A repeated position overwrites the earlier value. The
// word with final_element_i set is stored too, then busy_o rises and the
// drain begins. Drain: one grid position is examined per cycle in scan
// order, so a drain examines at most ROWS*COLS = 64 positions; the scan
// stops as soon as the last valid cell has been read, tracked by an
// occupancy counter. Each found cell is read from the cell RAM (registered
// read), so its result appears in the cycle after lookup, on result_valid_o
// for a single cycle. The receiver cannot stall: results must be taken as
// they come. last_of_run_o marks the final result; an empty matrix gives
// none. Valid marks are cleared cell by cell as they are drained, so the
// grid is clear for the next matrix when busy_o falls, and a new word may
// be accepted in the same cycle the last result is shown.
module anti_diagonal_reorder_top
  import adr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [VAL_W-1:0]  element_value_i,
  input  logic [RIDX_W-1:0]        row_index_i,
  input  logic [CIDX_W-1:0]        column_index_i,
  input  logic                     final_element_i,
  output logic                     result_valid_o,
  output logic signed [VAL_W-1:0]  out_value_o,
  output logic                     last_of_run_o
);

  adr_cmd_t  cmd;
  adr_stat_t stat;
  logic [VAL_W-1:0] value_raw;

  // sequencing: idle/load vs. drain scan
  adr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .final_element_i (final_element_i),
    .stat_i          (stat),
    .cmd_o           (cmd),
    .busy_o          (busy_o)
  );

  // storage and scan address generation
  adr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .element_value_i (element_value_i),
    .row_index_i     (row_index_i),
    .column_index_i  (column_index_i),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .out_value_o     (value_raw),
    .last_of_run_o   (last_of_run_o)
  );

  assign out_value_o = signed'(value_raw);

endmodule

// ----- hdl/adr_checker.sv -----
// Port-level checker for the anti-diagonal reorder top, with its bind.
`include "anti_diagonal_reorder_top_defines.svh"

module adr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic final_element_i,
  input logic result_valid_o,
  input logic last_of_run_o
);

  `ADR_ASSERT_NEXT(a_final_starts_drain, start_i && !busy_o && final_element_i, busy_o, "final word did not start a drain")
  `ADR_ASSERT_IMPLY(a_last_needs_strobe, last_of_run_o, result_valid_o, "last flag without a result")
  `ADR_ASSERT_IMPLY(a_last_ends_drain, result_valid_o && last_of_run_o, !busy_o, "still busy with the last result")
  `ADR_ASSERT_IMPLY(a_mid_result_busy, result_valid_o && !last_of_run_o, busy_o, "drain ended before its last result")
  `ADR_ASSERT_IMPLY(a_result_after_drain, !$past(busy_o), !result_valid_o, "result without a drain")

endmodule

bind anti_diagonal_reorder_top adr_checker u_adr_checker (.*);
